@@ hw/rtl/oldest_voice_stealing_allocator_defines.svh @@
// Assertion macros for the voice allocator.
// Depends on nothing; users need clk and arst_n in scope.
`ifndef OLDEST_VOICE_STEALING_ALLOCATOR_DEFINES_SVH
`define OLDEST_VOICE_STEALING_ALLOCATOR_DEFINES_SVH

// ante implies cons in the same cycle
`define OVSA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression must never hold
`define OVSA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

@@ hw/rtl/ovsa_pkg.sv @@
// Types and constants shared by the voice allocator modules.
// No dependencies.
package ovsa_pkg;

	localparam logic [6:0] NOTE_OFFSET   = 7'd12;
	localparam logic [6:0] PEDAL_LIMIT   = 7'd64;
	localparam logic [3:0] CH_ALT        = 4'd1;
	localparam logic [3:0] CH_RESERVED   = 4'd2;
	localparam logic [3:0] UNASSIGNED_CH = 4'd15;
	localparam logic [7:0] NO_NOTE       = 8'h80;
	localparam logic       REG_VOICES_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		OP_NOTE_ON  = 3'd0,
		OP_NOTE_OFF = 3'd1,
		OP_PEDAL    = 3'd2,
		OP_ALL_OFF  = 3'd3,
		OP_FINISHED = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_RETRIG  = 3'd2,
		ACT_RELEASE = 3'd3,
		ACT_HOLD    = 3'd4,
		ACT_SILENCE = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		VS_IDLE    = 2'd0,
		VS_BUSY    = 2'd1,
		VS_WAIT_UP = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SOUND   = 2'd1,
		PH_RELEASE = 2'd2,
		PH_FAST    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_PICK_RD,
		SQ_PICK_EX,
		SQ_FIN
	} seq_state_t;

	typedef struct packed {
		status_t    status;
		phase_t     phase;
		logic [7:0] cur_note;
		logic [7:0] queued_note;
		logic [3:0] chan_tag;
	} voice_fix_t;

	localparam voice_fix_t FIX_RESET = '{
		status:      VS_IDLE,
		phase:       PH_IDLE,
		cur_note:    NO_NOTE,
		queued_note: NO_NOTE,
		chan_tag:    UNASSIGNED_CH
	};

	typedef struct packed {
		logic [2:0] opcode;
		logic [6:0] midi_note;
		logic [3:0] midi_channel;
		logic [6:0] pedal_value;
		logic [4:0] finished_voice;
	} evt_t;

	typedef struct packed {
		logic [4:0] voice_index;
		logic [2:0] action;
		logic [6:0] voice_note;
		logic       last;
	} cmd_t;

endpackage

@@ hw/rtl/ovsa_voice_ram.sv @@
// Voice state memory: one write and one read port, registered read data.
// Per-entry valid flags report unwritten entries on rd_hit. Uses no package.
module ovsa_voice_ram #(
	parameter int DEPTH = 17,
	parameter int AW    = 5,
	parameter int DW    = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	output logic          rd_hit,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0] rd_data_q;
	logic rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

@@ hw/rtl/ovsa_cmd_buf.sv @@
// Command output stage: holds the newest command until the next one or the
// end of the event decides its last flag, then an output register. Uses ovsa_pkg.
module ovsa_cmd_buf
	import ovsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic fin,
	output logic room,
	output logic cmd_valid,
	input  logic cmd_stall,
	output cmd_t cmd
);

	logic pend_vld_q;
	cmd_t pend_q;
	logic out_vld_q;
	cmd_t out_q;
	logic out_free;
	logic move;

	assign out_free = !out_vld_q || !cmd_stall;
	assign room     = !pend_vld_q || out_free;
	assign move     = pend_vld_q && out_free && (push || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (push && room) begin
				pend_vld_q <= 1'b1;
			end else if (fin && room) begin
				pend_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (!cmd_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && room) begin
			pend_q <= push_cmd;
		end
		if (move) begin
			out_q <= '{voice_index: pend_q.voice_index, action: pend_q.action,
				voice_note: pend_q.voice_note, last: fin};
		end
	end

	assign cmd_valid = out_vld_q;
	assign cmd       = out_q;

endmodule

@@ hw/rtl/ovsa_seq.sv @@
// Event sequencer: walks the voice memory one entry per cycle while commands have
// room, read-modify-write, emitting commands. Uses ovsa_pkg and the macro header.
`include "oldest_voice_stealing_allocator_defines.svh"
module ovsa_seq
	import ovsa_pkg::*;
#(
	parameter int AGE_BITS   = 16,
	parameter int IDX_W      = 5,
	parameter int DW         = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic [IDX_W-1:0] nv,
	input  logic             evt_valid,
	output logic             evt_stall,
	input  evt_t             evt,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  logic [DW-1:0]    rd_data,
	input  logic             rd_hit,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output logic [DW-1:0]    wr_data,
	output logic             push,
	output cmd_t             push_cmd,
	output logic             fin,
	input  logic             room
);

	localparam int CW = (IDX_W > 5) ? IDX_W : 5;

	seq_state_t state_q, state_d;
	logic pedal_q;
	opcode_t op_q;
	logic [6:0] note_q;
	logic [3:0] ch_q;
	logic chres_q;
	logic [IDX_W-1:0] x_q, end_q, pick_q, oldest_q;
	logic found_q;
	logic [AGE_BITS-1:0] maxage_q;

	// accept-time decode
	logic acc, low, is_ch2, down;
	logic go_scan, go_pick;
	logic [IDX_W-1:0] first_idx, last_idx;

	// step datapath
	voice_fix_t e_fix, n_fix;
	logic [AGE_BITS-1:0] e_age, n_age, age_a;
	logic held, on_active, on_match, on_older;
	logic emit, ex, step_go, scan_end;
	action_t emit_act;
	logic [6:0] emit_note;
	logic [IDX_W-1:0] cur_idx, pick_sel;

	assign acc      = (state_q == SQ_IDLE) && evt_valid;
	assign low      = evt.midi_note < NOTE_OFFSET;
	assign is_ch2   = evt.midi_channel == CH_RESERVED;
	assign down     = evt.pedal_value >= PEDAL_LIMIT;
	assign e_fix    = rd_hit ? voice_fix_t'(rd_data[DW-1:AGE_BITS]) : FIX_RESET;
	assign e_age    = rd_hit ? rd_data[AGE_BITS-1:0] : '0;
	assign held     = (e_fix.cur_note == {1'b0, note_q}) ||
	                  (e_fix.queued_note == {1'b0, note_q});
	assign ex       = (state_q == SQ_SCAN) || (state_q == SQ_PICK_EX);
	assign step_go  = ex && (!emit || room);
	assign scan_end = x_q == end_q;
	assign cur_idx  = (state_q == SQ_PICK_EX) ? pick_q : x_q;
	assign pick_sel = found_q ? pick_q : oldest_q;

	always_comb begin
		go_scan   = 1'b0;
		go_pick   = 1'b0;
		first_idx = '0;
		last_idx  = nv;
		case (opcode_t'(evt.opcode))
			OP_NOTE_ON: begin
				if (!low) begin
					if (is_ch2) begin
						go_pick   = 1'b1;
						first_idx = nv;
					end else begin
						go_scan  = 1'b1;
						last_idx = nv - IDX_W'(1);
					end
				end
			end
			OP_NOTE_OFF: begin
				if (!low) begin
					go_scan = 1'b1;
					if (is_ch2) begin
						first_idx = nv;
					end else begin
						last_idx = nv - IDX_W'(1);
					end
				end
			end
			OP_PEDAL: begin
				go_scan = pedal_q && !down;
			end
			OP_ALL_OFF: begin
				go_scan = 1'b1;
			end
			OP_FINISHED: begin
				if (CW'(evt.finished_voice) <= CW'(nv)) begin
					go_scan   = 1'b1;
					first_idx = IDX_W'(evt.finished_voice);
					last_idx  = IDX_W'(evt.finished_voice);
				end
			end
			default: begin
				go_scan = 1'b0;
			end
		endcase
	end

	// note-on scan: ages and candidate tracking
	always_comb begin
		on_active = e_fix.status != VS_IDLE;
		on_match  = on_active && held && (e_fix.chan_tag == ch_q);
		age_a     = on_match ? '0 : e_age;
		if (on_active && (age_a != {AGE_BITS{1'b1}})) begin
			age_a = age_a + 1'b1;
		end
		on_older = on_active && (age_a > maxage_q);
	end

	// per-entry update and command
	always_comb begin
		n_fix     = e_fix;
		n_age     = e_age;
		emit      = 1'b0;
		emit_act  = ACT_NONE;
		emit_note = '0;
		if (state_q == SQ_PICK_EX) begin
			emit = 1'b1;
			if (e_fix.cur_note != NO_NOTE) begin
				n_fix.queued_note = {1'b0, note_q};
				n_fix.phase       = PH_FAST;
				emit_act          = ACT_RETRIG;
			end else begin
				n_fix.cur_note = {1'b0, note_q};
				n_fix.phase    = PH_SOUND;
				emit_act       = ACT_START;
			end
			emit_note      = note_q;
			n_fix.status   = VS_BUSY;
			n_age          = '0;
			n_fix.chan_tag = ((ch_q == CH_ALT) || (ch_q == CH_RESERVED)) ? ch_q : 4'd0;
		end else begin
			case (op_q)
				OP_NOTE_ON: begin
					n_age = age_a;
				end
				OP_NOTE_OFF: begin
					if ((chres_q || (e_fix.chan_tag == ch_q)) && held) begin
						emit = 1'b1;
						if (!chres_q) begin
							n_age = '0;
						end
						if ((e_fix.cur_note == {1'b0, note_q}) &&
						    (e_fix.queued_note != NO_NOTE)) begin
							n_fix.phase = PH_FAST;
							emit_act    = ACT_RETRIG;
							emit_note   = e_fix.queued_note[6:0];
						end else if (!pedal_q) begin
							n_fix.phase = PH_RELEASE;
							emit_act    = ACT_RELEASE;
						end else begin
							n_fix.status = VS_WAIT_UP;
							emit_act     = ACT_HOLD;
						end
					end
				end
				OP_PEDAL: begin
					if (e_fix.status == VS_WAIT_UP) begin
						emit        = 1'b1;
						n_fix.phase = PH_RELEASE;
						emit_act    = ACT_RELEASE;
					end
				end
				OP_ALL_OFF: begin
					emit              = 1'b1;
					n_fix.queued_note = NO_NOTE;
					n_fix.phase       = PH_FAST;
					n_age             = '0;
					emit_act          = ACT_SILENCE;
				end
				OP_FINISHED: begin
					if ((e_fix.status != VS_IDLE) && (e_fix.cur_note != NO_NOTE)) begin
						if ((e_fix.phase == PH_RELEASE) ||
						    ((e_fix.phase == PH_FAST) && (e_fix.queued_note == NO_NOTE))) begin
							emit           = 1'b1;
							n_fix.cur_note = NO_NOTE;
							n_fix.phase    = PH_IDLE;
							n_fix.status   = VS_IDLE;
							emit_act       = ACT_NONE;
						end else if (e_fix.phase == PH_FAST) begin
							emit              = 1'b1;
							n_fix.cur_note    = e_fix.queued_note;
							n_fix.queued_note = NO_NOTE;
							n_fix.phase       = PH_SOUND;
							emit_act          = ACT_START;
							emit_note         = e_fix.queued_note[6:0];
						end
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (acc && go_pick) begin
					state_d = SQ_PICK_EX;
				end else if (acc && go_scan) begin
					state_d = SQ_SCAN;
				end
			end
			SQ_SCAN: begin
				if (step_go && scan_end) begin
					state_d = (op_q == OP_NOTE_ON) ? SQ_PICK_RD : SQ_FIN;
				end
			end
			SQ_PICK_RD: begin
				state_d = SQ_PICK_EX;
			end
			SQ_PICK_EX: begin
				if (step_go) begin
					state_d = SQ_FIN;
				end
			end
			SQ_FIN: begin
				if (room) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = first_idx;
		case (state_q)
			SQ_IDLE: begin
				rd_en = acc && (go_scan || go_pick);
			end
			SQ_SCAN: begin
				rd_en   = step_go && !scan_end;
				rd_addr = x_q + IDX_W'(1);
			end
			SQ_PICK_RD: begin
				rd_en   = 1'b1;
				rd_addr = pick_sel;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		wr_en                = step_go;
		wr_addr              = cur_idx;
		wr_data              = {n_fix, n_age};
		push                 = step_go && emit;
		push_cmd.voice_index = 5'(cur_idx);
		push_cmd.action      = emit_act;
		push_cmd.voice_note  = emit_note;
		push_cmd.last        = 1'b0;
		fin                  = state_q == SQ_FIN;
		evt_stall            = state_q != SQ_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pedal_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr) begin
				pedal_q <= 1'b0;
			end else if (acc && (opcode_t'(evt.opcode) == OP_PEDAL)) begin
				pedal_q <= down;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= opcode_t'(evt.opcode);
			note_q   <= evt.midi_note - NOTE_OFFSET;
			ch_q     <= evt.midi_channel;
			chres_q  <= is_ch2;
			x_q      <= first_idx;
			end_q    <= last_idx;
			pick_q   <= nv;
			found_q  <= 1'b0;
			oldest_q <= '0;
			maxage_q <= '0;
		end else if (state_q == SQ_PICK_RD) begin
			pick_q <= pick_sel;
		end else if ((state_q == SQ_SCAN) && step_go) begin
			x_q <= x_q + IDX_W'(1);
			if (op_q == OP_NOTE_ON) begin
				if (on_match || (!on_active && !found_q)) begin
					pick_q  <= x_q;
					found_q <= 1'b1;
				end
				if (on_older) begin
					oldest_q <= x_q;
					maxage_q <= age_a;
				end
			end
		end
	end

	`OVSA_ASSERT_NEVER(a_rw_same_entry, wr_en && rd_en && (wr_addr == rd_addr), "read and write of one voice in a cycle")
	`OVSA_ASSERT_IMPL(a_push_room, push, room, "command pushed without room")
	`OVSA_ASSERT_NEVER(a_push_fin, push && fin, "push during event end")
	`OVSA_ASSERT_IMPL(a_scan_bound, state_q == SQ_SCAN, x_q <= end_q, "scan index past end")

endmodule

@@ hw/rtl/oldest_voice_stealing_allocator.sv @@
// Each event read-modify-writes the voices it visits, in order: note-on
// off channel 2 scans the voices below voices_in_use, then pick read, update, end;
// note-off off channel 2 visits those voices, pedal-up and all-notes-off also the
// reserved voice, other note and envelope-finished events one voice; output stalls hold
// the walk. Commands leave via a pending slot plus output register, one transfer/cycle
// unless stalled. Reset/voices_in_use writes: pedal, voices (valid flags) idle at once.
module oldest_voice_stealing_allocator
	import ovsa_pkg::*;
#(
	parameter int MAX_VOICES = 16,
	parameter int AGE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        evt_valid,
	output logic        evt_stall,
	input  evt_t        evt,
	// command channel
	output logic        cmd_valid,
	input  logic        cmd_stall,
	output cmd_t        cmd,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BANK     = MAX_VOICES + 1;
	localparam int IDX_W    = $clog2(MAX_VOICES + 1);
	localparam int DW       = $bits(voice_fix_t) + AGE_BITS;
	localparam int CW       = (IDX_W > 5) ? IDX_W : 5;
	localparam int NV_RESET = (MAX_VOICES < 16) ? MAX_VOICES : 16;

	logic [IDX_W-1:0] nv_q;
	logic cfg_wr;
	logic [4:0] wv;
	logic [IDX_W-1:0] wv_sat;

	logic rd_en, rd_hit, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [DW-1:0] rd_data, wr_data;
	logic push, fin, room;
	cmd_t push_cmd;

	// register write: voice count saturates into 1..MAX_VOICES
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VOICES_IN_USE);
	assign wv     = pwdata[4:0];

	always_comb begin
		if (wv == 5'd0) begin
			wv_sat = IDX_W'(1);
		end else if (CW'(wv) > CW'(MAX_VOICES)) begin
			wv_sat = IDX_W'(MAX_VOICES);
		end else begin
			wv_sat = IDX_W'(wv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= IDX_W'(NV_RESET);
		end else if (cfg_wr) begin
			nv_q <= wv_sat;
		end
	end

	assign prdata = (paddr[2] == REG_VOICES_IN_USE) ? 32'(nv_q) : 32'd0;

	// one entry per voice plus the reserved channel voice
	ovsa_voice_ram #(
		.DEPTH(BANK),
		.AW   (IDX_W),
		.DW   (DW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_wr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.rd_hit (rd_hit),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	ovsa_seq #(
		.AGE_BITS  (AGE_BITS),
		.IDX_W     (IDX_W),
		.DW        (DW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (cfg_wr),
		.nv       (nv_q),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.rd_hit   (rd_hit),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.push_cmd (push_cmd),
		.fin      (fin),
		.room     (room)
	);

	// the last flag is settled when the next command or the event end arrives
	ovsa_cmd_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.fin      (fin),
		.room     (room),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd)
	);

endmodule

@@ dv/tb_oldest_voice_stealing_allocator.sv @@
// Self-checking testbench for oldest_voice_stealing_allocator: scripted events,
// then shaped random traffic; commands checked against typed rows or a voice-bank model.
// Depends on ovsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_oldest_voice_stealing_allocator;
	import ovsa_pkg::*;

	localparam int          MAX_V      = 16;
	localparam int unsigned AGE_TOP    = 65535;   // 16-bit ages saturate here
	localparam int          SETTLE     = 60;      // idle wait after the owed commands drain
	localparam int          LONG_HOLD  = 200;     // receiver back-pressure stretch
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int          EVT_W      = $bits(evt_t);

	// opcodes the block must ignore; they have no name in the package
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// one scripted event; want < 0 means the bank model supplies the expectation,
	// otherwise want (0 or 1) commands are typed in below
	typedef struct {
		evt_t ev;
		int   want;
		cmd_t cmd;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_stall;
	evt_t        evt;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	oldest_voice_stealing_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Voice bank model: mirrors the allocator state, one entry per voice
	// plus the reserved channel-2 voice at index n_voices.
	// ---------------------------------------------------------------
	int          n_voices;
	status_t     v_status [0:MAX_V];
	phase_t      v_phase  [0:MAX_V];
	logic [7:0]  v_cur    [0:MAX_V];
	logic [7:0]  v_queued [0:MAX_V];
	logic [3:0]  v_tag    [0:MAX_V];
	int unsigned v_age    [0:MAX_V];
	bit          pedal_is_down;

	cmd_t fresh_cmds[$];   // commands of the event being modeled
	cmd_t cmd_due[$];      // commands still owed by the DUT, oldest first

	int   row_want = -1;   // typed expectation of the scripted event in flight
	cmd_t row_cmd;
	int   mismatches = 0;
	bit   calm = 1'b0;          // tail of the run: no idling on either side
	bit   hold_request = 1'b0;  // asks the receiver for one long stall
	int unsigned cycle_count = 0;

	step_t plan[$];

	function automatic void clear_bank();
		for (int x = 0; x <= MAX_V; x++) begin
			v_status[x] = VS_IDLE;
			v_phase[x]  = PH_IDLE;
			v_cur[x]    = NO_NOTE;
			v_queued[x] = NO_NOTE;
			v_tag[x]    = UNASSIGNED_CH;
			v_age[x]    = 0;
		end
		pedal_is_down = 1'b0;
	endfunction

	function automatic void add_cmd(int v, action_t a, logic [6:0] n);
		fresh_cmds.push_back('{voice_index: v[4:0], action: a, voice_note: n, last: 1'b0});
	endfunction

	function automatic bit holds(int v, logic [6:0] n);
		return v_cur[v] == {1'b0, n} || v_queued[v] == {1'b0, n};
	endfunction

	// note-off on a voice: fast release into the queued note, else release or pedal hold
	function automatic void release_voice(int v, logic [6:0] n);
		if (v_cur[v] == {1'b0, n} && v_queued[v] != NO_NOTE) begin
			v_phase[v] = PH_FAST;
			add_cmd(v, ACT_RETRIG, v_queued[v][6:0]);
		end else if (!pedal_is_down) begin
			v_phase[v] = PH_RELEASE;
			add_cmd(v, ACT_RELEASE, 7'd0);
		end else begin
			v_status[v] = VS_WAIT_UP;
			add_cmd(v, ACT_HOLD, 7'd0);
		end
	endfunction

	// note-on: same note+channel reuse, else lowest idle voice, else the oldest one
	function automatic void play_note(logic [6:0] n, logic [3:0] ch);
		int          pick;
		int          oldest;
		int unsigned top;
		bit          found;
		bit          active;
		pick   = 0;
		oldest = 0;
		top    = 0;
		found  = 1'b0;
		if (ch == CH_RESERVED) begin
			pick = n_voices;
		end else begin
			for (int x = 0; x < n_voices; x++) begin
				active = v_status[x] != VS_IDLE;
				if (active && holds(x, n) && v_tag[x] == ch) begin
					pick     = x;
					found    = 1'b1;
					v_age[x] = 0;
				end
				if (active) begin
					if (v_age[x] < AGE_TOP)
						v_age[x]++;
					if (v_age[x] > top) begin
						oldest = x;
						top    = v_age[x];
					end
				end else if (!found) begin
					pick  = x;
					found = 1'b1;
				end
			end
			if (!found)
				pick = oldest;
		end
		if (v_cur[pick] != NO_NOTE) begin
			v_queued[pick] = {1'b0, n};
			v_phase[pick]  = PH_FAST;
			add_cmd(pick, ACT_RETRIG, n);
		end else begin
			v_cur[pick]   = {1'b0, n};
			v_phase[pick] = PH_SOUND;
			add_cmd(pick, ACT_START, n);
		end
		v_status[pick] = VS_BUSY;
		v_age[pick]    = 0;
		v_tag[pick]    = (ch == CH_ALT || ch == CH_RESERVED) ? ch : 4'd0;
	endfunction

	// envelope reached zero: start the queued note or let the voice go idle
	function automatic void finish_voice(logic [4:0] fv);
		if (fv > n_voices || v_status[fv] == VS_IDLE || v_cur[fv] == NO_NOTE)
			return;
		if (v_phase[fv] == PH_FAST && v_queued[fv] != NO_NOTE) begin
			v_cur[fv]    = v_queued[fv];
			v_queued[fv] = NO_NOTE;
			v_phase[fv]  = PH_SOUND;
			add_cmd(fv, ACT_START, v_cur[fv][6:0]);
		end else if (v_phase[fv] == PH_RELEASE || v_phase[fv] == PH_FAST) begin
			v_cur[fv]    = NO_NOTE;
			v_phase[fv]  = PH_IDLE;
			v_status[fv] = VS_IDLE;
			add_cmd(fv, ACT_NONE, 7'd0);
		end
	endfunction

	function automatic void apply_event(evt_t e);
		logic [6:0] n;
		bit         down;
		n = e.midi_note - NOTE_OFFSET;
		case (e.opcode)
			OP_NOTE_ON: begin
				if (e.midi_note >= NOTE_OFFSET)
					play_note(n, e.midi_channel);
			end
			OP_NOTE_OFF: begin
				if (e.midi_note >= NOTE_OFFSET) begin
					if (e.midi_channel == CH_RESERVED) begin
						if (holds(n_voices, n))
							release_voice(n_voices, n);
					end else begin
						for (int x = 0; x < n_voices; x++)
							if (v_tag[x] == e.midi_channel && holds(x, n)) begin
								release_voice(x, n);
								v_age[x] = 0;
							end
					end
				end
			end
			OP_PEDAL: begin
				// only the down-to-up change frees voices held by the pedal
				down = e.pedal_value >= PEDAL_LIMIT;
				if (pedal_is_down && !down)
					for (int x = 0; x <= n_voices; x++)
						if (v_status[x] == VS_WAIT_UP) begin
							v_phase[x] = PH_RELEASE;
							add_cmd(x, ACT_RELEASE, 7'd0);
						end
				pedal_is_down = down;
			end
			OP_ALL_OFF: begin
				for (int x = 0; x <= n_voices; x++) begin
					v_queued[x] = NO_NOTE;
					v_phase[x]  = PH_FAST;
					v_age[x]    = 0;
					add_cmd(x, ACT_SILENCE, 7'd0);
				end
			end
			OP_FINISHED: finish_voice(e.finished_voice);
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Stimulus shaping: mostly events that hit live voices, some noise.
	// ---------------------------------------------------------------
	function automatic evt_t next_event();
		evt_t e;
		int   r;
		int   k;
		int   hits[$];
		e = evt_t'(EVT_W'($urandom));   // every field starts as noise
		r = $urandom_range(0, 99);
		if (r < 38) begin
			e.opcode = OP_NOTE_ON;
			if ($urandom_range(0, 4) != 0) begin
				// small note pool so retrigger, reuse and stealing occur
				e.midi_note = 7'(60 + $urandom_range(0, 7));
				k = $urandom_range(0, 9);
				e.midi_channel = (k < 3) ? 4'd0 : (k < 5) ? CH_ALT :
					(k < 7) ? CH_RESERVED : e.midi_channel;
			end
		end else if (r < 58) begin
			e.opcode = OP_NOTE_OFF;
			for (int x = 0; x <= n_voices; x++)
				if (v_cur[x] != NO_NOTE || v_queued[x] != NO_NOTE)
					hits.push_back(x);
			if (hits.size() > 0 && $urandom_range(0, 5) != 0) begin
				k = hits[$urandom_range(0, hits.size() - 1)];
				if (v_cur[k] != NO_NOTE && (v_queued[k] == NO_NOTE || $urandom_range(0, 1)))
					e.midi_note = v_cur[k][6:0] + NOTE_OFFSET;
				else
					e.midi_note = v_queued[k][6:0] + NOTE_OFFSET;
				e.midi_channel = (k == n_voices) ? CH_RESERVED : v_tag[k];
			end
		end else if (r < 76) begin
			e.opcode = OP_FINISHED;
			for (int x = 0; x <= n_voices; x++)
				if (v_status[x] != VS_IDLE && v_cur[x] != NO_NOTE &&
				    (v_phase[x] == PH_RELEASE || v_phase[x] == PH_FAST))
					hits.push_back(x);
			if (hits.size() > 0 && $urandom_range(0, 5) != 0)
				e.finished_voice = 5'(hits[$urandom_range(0, hits.size() - 1)]);
		end else if (r < 86) begin
			e.opcode = OP_PEDAL;
		end else if (r < 91) begin
			e.opcode = OP_ALL_OFF;
		end else if (r < 95) begin
			e.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else begin
			e.opcode = OP_NOTE_OFF;   // stray note-off, random note and channel
		end
		return e;
	endfunction

	function automatic step_t step(logic [2:0] op, logic [6:0] note, logic [3:0] ch,
		logic [6:0] ped, logic [4:0] fv, int want, logic [4:0] vi, action_t a, logic [6:0] vn);
		step_t s;
		s.ev   = '{opcode: op, midi_note: note, midi_channel: ch, pedal_value: ped,
			finished_voice: fv};
		s.want = want;
		s.cmd  = '{voice_index: vi, action: a, voice_note: vn, last: 1'b1};
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: model each accepted event, then check each command transfer.
	// Both run on the pre-edge values, so they see what the DUT saw.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		cmd_t due;
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				apply_event(evt);
				if (row_want >= 0) begin
					if (row_want == 1)
						cmd_due.push_back(row_cmd);
				end else begin
					if (fresh_cmds.size() > 0)
						fresh_cmds[fresh_cmds.size() - 1].last = 1'b1;
					foreach (fresh_cmds[i])
						cmd_due.push_back(fresh_cmds[i]);
				end
				fresh_cmds.delete();
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd_due.size() == 0) begin
					$error("unexpected command: voice_index %0d action %0d voice_note %0d",
						cmd.voice_index, cmd.action, cmd.voice_note);
					mismatches++;
				end else begin
					due = cmd_due.pop_front();
					if (cmd.voice_index !== due.voice_index) begin
						$error("voice_index expected %0d actual %0d", due.voice_index,
							cmd.voice_index);
						mismatches++;
					end
					if (cmd.action !== due.action) begin
						$error("action expected %0d actual %0d", due.action, cmd.action);
						mismatches++;
					end
					if (cmd.voice_note !== due.voice_note) begin
						$error("voice_note expected %0d actual %0d", due.voice_note,
							cmd.voice_note);
						mismatches++;
					end
					if (cmd.last !== due.last) begin
						$error("last expected %0d actual %0d", due.last, cmd.last);
						mismatches++;
					end
				end
			end
		end
	end

	// Receiver: random stall bursts, one long hold on request, none in the tail.
	// The long hold is counted here so the sender keeps offering meanwhile.
	initial begin : receiver
		int unsigned stall_run;
		stall_run = 0;
		cmd_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_run    = LONG_HOLD;
			end else if (stall_run == 0 && !calm && $urandom_range(0, 5) == 0) begin
				stall_run = $urandom_range(1, 6);
			end
			cmd_stall <= (stall_run != 0);
			if (stall_run != 0)
				stall_run--;
		end
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_oldest_voice_stealing_allocator NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------
	// Drivers; every task is entered and left at a falling edge.
	// ---------------------------------------------------------------

	// one event transfer, optionally after a random gap with valid low
	task automatic push_event(input evt_t e);
		if (!calm && $urandom_range(0, 3) == 0) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		evt       <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// setup then access phase; leaves the bus idle after so calls can be chained
	task automatic reg_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_VOICES_IN_USE, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_voices_reg(input logic [4:0] want);
		logic [31:0] rd;
		reg_access(1'b0, '0, rd);
		if (rd[4:0] !== want) begin
			$error("voices_in_use expected %0d actual %0d", want, rd[4:0]);
			mismatches++;
		end
	endtask

	// stop offering, wait for every owed command, then for events that owe none
	task automatic settle();
		evt_valid <= 1'b0;
		while (cmd_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// resize the bank; the write also clears all voices and the pedal
	task automatic retune(input logic [4:0] value);
		logic [31:0] rd;
		settle();
		reg_access(1'b1, {27'd0, value}, rd);
		n_voices = (value == 0) ? 1 : (value > MAX_V) ? MAX_V : value;
		clear_bank();
		if (value >= 1 && value <= MAX_V)
			check_voices_reg(value);
	endtask

	task automatic random_items(input int count);
		evt_t e;
		int   sent;
		sent     = 0;
		row_want = -1;
		while (sent < count) begin
			e = next_event();
			push_event(e);
			if (e.opcode <= OP_FINISHED)   // ignored opcodes do not count
				sent++;
		end
	endtask

	initial begin : main
		arst_n    = 1'b0;
		evt_valid = 1'b0;
		evt       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		n_voices  = MAX_V;
		clear_bank();

		// scripted events on the reset bank of 16 voices
		plan.push_back(step(OP_NOTE_ON, 11, 0, 0, 0, 0, 0, ACT_NONE, 0));    // note below range
		plan.push_back(step(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, ACT_NONE, 0));    // note below range
		plan.push_back(step(OP_NOTE_ON, 12, 0, 0, 0, 1, 0, ACT_START, 0));   // lowest note
		plan.push_back(step(OP_NOTE_ON, 127, 15, 0, 0, 1, 1, ACT_START, 115)); // next idle voice
		plan.push_back(step(OP_NOTE_ON, 60, CH_RESERVED, 0, 0, 1, 16, ACT_START, 48));
		plan.push_back(step(OP_NOTE_ON, 60, CH_RESERVED, 0, 0, 1, 16, ACT_RETRIG, 48));
		plan.push_back(step(OP_NOTE_ON, 12, 0, 0, 0, -1, 0, ACT_NONE, 0));   // reuse voice 0
		plan.push_back(step(OP_NOTE_OFF, 12, 0, 0, 0, -1, 0, ACT_NONE, 0));  // into queued note
		plan.push_back(step(OP_FINISHED, 0, 0, 0, 0, -1, 0, ACT_NONE, 0));   // queued note starts
		plan.push_back(step(OP_PEDAL, 0, 0, 127, 0, 0, 0, ACT_NONE, 0));     // pedal down
		plan.push_back(step(OP_NOTE_OFF, 127, 0, 0, 0, -1, 0, ACT_NONE, 0)); // held by pedal
		plan.push_back(step(OP_NOTE_OFF, 12, 0, 0, 0, -1, 0, ACT_NONE, 0));  // held by pedal
		plan.push_back(step(OP_PEDAL, 0, 0, 64, 0, 0, 0, ACT_NONE, 0));      // still down
		plan.push_back(step(OP_PEDAL, 0, 0, 63, 0, -1, 0, ACT_NONE, 0));     // up: two releases
		plan.push_back(step(OP_FINISHED, 0, 0, 0, 1, -1, 0, ACT_NONE, 0));   // release ends
		plan.push_back(step(OP_FINISHED, 0, 0, 0, 31, 0, 0, ACT_NONE, 0));   // beyond the bank
		plan.push_back(step(OP_FINISHED, 0, 0, 0, 5, 0, 0, ACT_NONE, 0));    // idle voice
		plan.push_back(step(OP_NOTE_ON, 40, CH_ALT, 0, 0, -1, 0, ACT_NONE, 0));
		plan.push_back(step(OP_NOTE_OFF, 40, 0, 0, 0, 0, 0, ACT_NONE, 0));   // channel mismatch
		plan.push_back(step(OP_UNUSED_LO, 60, 0, 0, 0, 0, 0, ACT_NONE, 0));
		plan.push_back(step(OP_UNUSED_HI, 60, 0, 0, 0, 0, 0, ACT_NONE, 0));
		plan.push_back(step(OP_ALL_OFF, 0, 0, 0, 0, -1, 0, ACT_NONE, 0));    // whole bank
		plan.push_back(step(OP_FINISHED, 0, 0, 0, 16, -1, 0, ACT_NONE, 0));  // queue was dropped
		plan.push_back(step(OP_NOTE_OFF, 60, CH_RESERVED, 0, 0, -1, 0, ACT_NONE, 0));
		plan.push_back(step(OP_PEDAL, 0, 0, 0, 0, 0, 0, ACT_NONE, 0));       // up while up

		// single reset, released on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		check_voices_reg(5'(MAX_V));
		foreach (plan[i]) begin
			row_want = plan[i].want;
			row_cmd  = plan[i].cmd;
			push_event(plan[i].ev);
		end
		row_want = -1;

		// one-voice bank: every note-on off channel 2 takes voice 0, stealing or reusing it when busy
		retune(5'd1);
		random_items(20);
		// zero saturates to one voice
		retune(5'd0);
		random_items(20);
		// oversize value saturates to the full bank; receiver holds off long
		// enough that the output fills and event transfers back up
		retune(5'd31);
		hold_request = 1'b1;
		random_items(25);
		// small bank, heavy stealing
		retune(5'($urandom_range(2, 5)));
		random_items(25);
		// full bank, no idling on either side
		calm = 1'b1;
		retune(5'(MAX_V));
		random_items(20);

		settle();
		if (mismatches == 0)
			$display("tb_oldest_voice_stealing_allocator OK");
		else
			$display("tb_oldest_voice_stealing_allocator NOT OK");
		$finish;
	end

endmodule
